### design/hdif_pkg.sv
// Package with payload types and constants for the hard disk insertion filter.
package hdif_pkg;

	localparam int unsigned CoordW = 16;
	localparam int unsigned SigmaW = 33;
	localparam int unsigned DistW  = 34;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 33;

	localparam logic [CfgIdxW-1:0] CFG_BOX_WIDTH     = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_BOX_HEIGHT    = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_SIGMA_SQUARED = 2'd2;

	typedef struct packed {
		logic [15:0] rand_x;
		logic [15:0] rand_y;
	} hdif_in_t;

	typedef struct packed {
		logic        accepted;
		logic [7:0]  slot;
		logic [8:0]  placed_count;
		logic        store_full;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
	} hdif_out_t;

	// Token handed from cell to cell: a candidate and its overlap flag so far.
	typedef struct packed {
		logic        live;
		logic        hit;
		logic [15:0] px;
		logic [15:0] py;
	} hdif_tok_t;

endpackage

### design/hdif_cell.sv
// One cell of the chain: holds one stored centre and checks a passing candidate.
module hdif_cell
	import hdif_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             load,
	input  logic [15:0]      load_x,
	input  logic [15:0]      load_y,
	input  logic [SigmaW-1:0] sigma_squared,
	input  hdif_tok_t        tok_in,
	output hdif_tok_t        tok_out
);

	logic        full_q;
	logic [15:0] cx_q;
	logic [15:0] cy_q;
	logic [15:0] dx;
	logic [15:0] dy;
	logic [31:0] dx2;
	logic [31:0] dy2;
	logic [DistW-1:0] dist2;
	logic        near;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (clear) begin
			full_q <= 1'b0;
		end else if (load) begin
			full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cx_q <= load_x;
			cy_q <= load_y;
		end
	end

	always_comb begin
		dx    = (tok_in.px >= cx_q) ? tok_in.px - cx_q : cx_q - tok_in.px;
		dy    = (tok_in.py >= cy_q) ? tok_in.py - cy_q : cy_q - tok_in.py;
		dx2   = dx * dx;
		dy2   = dy * dy;
		dist2 = {2'b00, dx2} + {2'b00, dy2};
		near  = full_q && ({1'b0, sigma_squared} > dist2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else begin
			tok_out.live <= tok_in.live;
			tok_out.hit  <= tok_in.hit | (tok_in.live & near);
			tok_out.px   <= tok_in.px;
			tok_out.py   <= tok_in.py;
		end
	end

endmodule

### design/hard_disk_insertion_filter.sv
// Top level of the hard disk insertion filter: scaling, cell chain and result register.
//
// Input channel in_valid/in_stall/in_data carries rand_x and rand_y; the output
// channel out_valid/out_stall/out_data carries one result per input transaction.
// Each transaction is scaled by the box extents (registered multiply),
// then travels down a chain of MAX_DISKS cells, one cell per cycle. Each cell
// holds one stored centre and marks an overlap when the squared distance is
// below sigma_squared. At the chain end the candidate is written into the next
// free cell if nothing overlapped and the store has room.
// The result is registered from the token that leaves the last cell. One transaction
// is in the block at a time, so the next input is taken only once the previous one
// has left the chain.
// A held result blocks the input: while the result waits under out_stall, no
// new candidate is taken, so the result register never gets overwritten.
// Reset empties the store, loads the register defaults and clears all valids.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must do so
// only while idle, as the block itself does not enforce it.
module hard_disk_insertion_filter
	import hdif_pkg::*;
#(
	parameter int unsigned MAX_DISKS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  hdif_in_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output hdif_out_t           out_data
);

	localparam int unsigned CntW = $clog2(MAX_DISKS + 1);

	logic [15:0]       box_width_q;
	logic [15:0]       box_height_q;
	logic [SigmaW-1:0] sigma_q;
	logic [CntW-1:0]   count_q;
	logic              busy_q;
	logic              scale_v_s1;
	logic [31:0]       prod_x_s1;
	logic [31:0]       prod_y_s1;
	logic              in_fire;
	logic              done;
	logic              store_ok;
	hdif_tok_t         chain [MAX_DISKS+1];
	logic [MAX_DISKS-1:0] load_vec;

	assign in_fire  = in_valid && !in_stall;
	assign in_stall = busy_q || (out_valid && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_width_q  <= 16'd25600;
			box_height_q <= 16'd25600;
			sigma_q      <= 33'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BOX_WIDTH:     box_width_q  <= cfg_data[15:0];
				CFG_BOX_HEIGHT:    box_height_q <= cfg_data[15:0];
				CFG_SIGMA_SQUARED: sigma_q      <= cfg_data[SigmaW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_v_s1 <= 1'b0;
		end else begin
			scale_v_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			prod_x_s1 <= in_data.rand_x * box_width_q;
			prod_y_s1 <= in_data.rand_y * box_height_q;
		end
	end

	assign chain[0] = '{live: scale_v_s1, hit: 1'b0,
		px: prod_x_s1[31:16], py: prod_y_s1[31:16]};

	assign done     = chain[MAX_DISKS].live;
	assign store_ok = done && !chain[MAX_DISKS].hit && (count_q < CntW'(MAX_DISKS));

	always_comb begin
		for (int i = 0; i < MAX_DISKS; i++) begin
			load_vec[i] = store_ok && (count_q == CntW'(i));
		end
	end

	for (genvar g = 0; g < MAX_DISKS; g++) begin : g_cell
		hdif_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.clear        (1'b0),
			.load         (load_vec[g]),
			.load_x       (chain[MAX_DISKS].px),
			.load_y       (chain[MAX_DISKS].py),
			.sigma_squared(sigma_q),
			.tok_in       (chain[g]),
			.tok_out      (chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (in_fire) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (store_ok) begin
				count_q <= count_q + 1'b1;
			end
			if (done) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_data.accepted     <= store_ok;
			out_data.slot         <= store_ok ? 8'(count_q) : 8'd0;
			out_data.placed_count <= 9'(store_ok ? count_q + 1'b1 : count_q);
			out_data.store_full   <= store_ok ? (count_q == CntW'(MAX_DISKS - 1))
			                                  : (count_q == CntW'(MAX_DISKS));
			out_data.pos_x        <= chain[MAX_DISKS].px;
			out_data.pos_y        <= chain[MAX_DISKS].py;
		end
	end

endmodule
